/* src/assert_macros.svh */
// assertion helpers shared by the rtl, empty in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property holds on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/vtc_pkg.sv */
// ----------------------------------------------------------------------------
// vtc_pkg
// Types and constants of the variometer tone controller.
// ----------------------------------------------------------------------------
package vtc_pkg;

  localparam int VelW   = 16;
  localparam int TimeW  = 32;
  localparam int HzW    = 11;
  localparam int LevelW = 4;
  localparam int ThrW   = 8;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  // clamped speed magnitude, 0..10000
  localparam int SpdW = 14;
  localparam logic signed [VelW-1:0] VelClamp = 16'sd10000;

  // frequency: floor(141*u/1000) + 386, divide by reciprocal multiply
  localparam int ProdW      = 21;
  localparam int RecipW     = 42;
  localparam int RecipShift = 30;
  localparam logic [ProdW-1:0] FreqMul  = 21'd141;
  localparam logic [ProdW-1:0] RecipK   = 21'd1073742;
  localparam logic [HzW-1:0]   FreqBase = 11'd386;
  localparam logic [HzW-1:0]   SinkHz   = 11'd100;

  // period: floor(150000000 / (51*u + 162000)), quotient always below 2^10
  localparam int DivW  = 20;
  localparam int PerW  = 10;
  localparam int NumW  = 28;
  localparam int CntW  = $clog2(PerW + 1);
  localparam logic [NumW-1:0] PeriodNum  = 28'd150000000;
  localparam logic [DivW-1:0] PeriodMul  = 20'd51;
  localparam logic [DivW-1:0] PeriodBase = 20'd162000;

  localparam logic [LevelW-1:0] VolumeReset = 4'd10;
  localparam logic [ThrW-1:0]   ClimbReset  = 8'd0;
  localparam logic [ThrW-1:0]   SinkReset   = 8'h80;

  localparam logic [AddrW-3:0] RegToneVolume    = 2'd0;
  localparam logic [AddrW-3:0] RegClimbThreshold = 2'd1;
  localparam logic [AddrW-3:0] RegSinkThreshold  = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_PLAY    = 2'd1,
    ACT_SILENCE = 2'd2
  } action_e;

  typedef struct packed {
    logic [LevelW-1:0] tone_volume;
    logic [ThrW-1:0]   climb_threshold;
    logic [ThrW-1:0]   sink_threshold;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

/* src/vtc_if.sv */
// ----------------------------------------------------------------------------
// vtc_if
// Valid/ready channels for velocity samples and tone requests.
// ----------------------------------------------------------------------------
interface vtc_sample_if import vtc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VelW-1:0]  vertical_speed;
  logic        [TimeW-1:0] now_ms;

  modport source (output valid, output vertical_speed, output now_ms, input ready);
  modport sink   (input valid, input vertical_speed, input now_ms, output ready);
endinterface

interface vtc_result_if import vtc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [HzW-1:0]    tone_hz;
  logic [LevelW-1:0] tone_level;

  modport source (output valid, output action, output tone_hz, output tone_level,
                  input ready);
  modport sink   (input valid, input action, input tone_hz, input tone_level,
                  output ready);
endinterface

/* src/vario_tone_controller_core.sv */
// ----------------------------------------------------------------------------
// vario_tone_controller_core
// Variometer tone controller with apb configuration registers.
// ----------------------------------------------------------------------------
// usage:
//   sample_i carries one velocity sample (vertical_speed, now_ms) per request;
//   result_o returns exactly one tone request (action, tone_hz, tone_level)
//   for each sample, in order.
//   registers: tone_volume at 0x0, climb_threshold at 0x4, sink_threshold
//   at 0x8; write them only while no sample is in flight.
// timing:
//   a sample is taken while the sequencer is idle; it then passes the
//   prepare, start, divide and decide states, and the next sample is taken
//   only after its result is committed. the ten-step period divider sets the pace.
// reset:
//   sounding cleared, beep start time zero, registers at their defaults,
//   result register empty.
// stall:
//   a finished result waits in the output register; the next sample is
//   still accepted and worked on, and stops before hand-off until the
//   receiver takes the waiting result.
// ----------------------------------------------------------------------------
module vario_tone_controller_core import vtc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  vtc_sample_if.sink       sample_i,
  vtc_result_if.source     result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;
  logic [AddrW-3:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tone_volume     <= VolumeReset;
      cfg_q.climb_threshold <= ClimbReset;
      cfg_q.sink_threshold  <= SinkReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegToneVolume:     cfg_q.tone_volume     <= pwdata[LevelW-1:0];
        RegClimbThreshold: cfg_q.climb_threshold <= pwdata[ThrW-1:0];
        RegSinkThreshold:  cfg_q.sink_threshold  <= pwdata[ThrW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegToneVolume:     prdata = DataW'(cfg_q.tone_volume);
      RegClimbThreshold: prdata = DataW'(cfg_q.climb_threshold);
      RegSinkThreshold:  prdata = DataW'(cfg_q.sink_threshold);
      default:           prdata = '0;
    endcase
  end

  vtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vtc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_i            (cfg_q),
    .vertical_speed_i (sample_i.vertical_speed),
    .now_ms_i         (sample_i.now_ms),
    .out_ready_i      (result_o.ready),
    .out_valid_o      (result_o.valid),
    .action_o         (result_o.action),
    .tone_hz_o        (result_o.tone_hz),
    .tone_level_o     (result_o.tone_level)
  );

endmodule

/* src/vtc_div.sv */
// ----------------------------------------------------------------------------
// vtc_div
// Restoring divider for the beep period, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtc_div import vtc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] divisor_i,
  output logic [PerW-1:0] quot_o,
  output logic            busy_o
);

  logic [DivW-1:0] rem_q, rem_d;
  logic [PerW-1:0] num_q, num_d;
  logic [PerW-1:0] quot_q, quot_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DivW:0]   trial;
  logic [DivW:0]   diff;
  logic            fits;

  assign trial = {rem_q, num_q[PerW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      // upper numerator bits are already below the smallest divisor
      rem_d  = DivW'(PeriodNum[NumW-1:PerW]);
      num_d  = PeriodNum[PerW-1:0];
      quot_d = '0;
      cnt_d  = CntW'(PerW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DivW-1:0] : trial[DivW-1:0];
      num_d  = {num_q[PerW-2:0], 1'b0};
      quot_d = {quot_q[PerW-2:0], fits};
      cnt_d  = cnt_q - CntW'(1);
      busy_d = (cnt_q != CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign busy_o = busy_q;

  `ASSERT_IMPLIES(a_busy_has_steps, clk_i, rst_ni, busy_q, cnt_q != '0)

endmodule

/* src/vtc_dp.sv */
// ----------------------------------------------------------------------------
// vtc_dp
// Datapath: sample capture, frequency and period, rule decision, beep state
// and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtc_dp import vtc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  cfg_t                    cfg_i,
  input  logic signed [VelW-1:0]  vertical_speed_i,
  input  logic        [TimeW-1:0] now_ms_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [1:0]              action_o,
  output logic [HzW-1:0]          tone_hz_o,
  output logic [LevelW-1:0]       tone_level_o
);

  logic signed [VelW-1:0] vs_q;
  logic [TimeW-1:0]       now_q;
  logic [ProdW-1:0]       prod_q;
  logic [DivW-1:0]        divisor_q;
  logic [HzW-1:0]         freq_q;
  logic                   sounding_q, sounding_d;
  logic [TimeW-1:0]       beep_start_q, beep_start_d;
  logic                   out_valid_q, out_valid_d;
  action_e                out_action_q, act;
  logic [HzW-1:0]         out_hz_q, hz;
  logic [LevelW-1:0]      out_level_q;

  logic [SpdW-1:0]        spd;
  logic [RecipW-1:0]      recip_prod;
  logic [PerW-1:0]        period;
  logic                   div_busy;
  logic                   expired;
  logic signed [VelW-1:0] climb_s;
  logic signed [VelW-1:0] sink_s;
  logic                   above_climb;
  logic                   below_climb;
  logic                   below_sink;
  logic                   out_quiet;

  vtc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.start),
    .divisor_i (divisor_q),
    .quot_o    (period),
    .busy_o    (div_busy)
  );

  // speed magnitude with negatives taken as zero and the upper clamp
  always_comb begin
    if (vs_q[VelW-1]) begin
      spd = '0;
    end else if (vs_q > VelClamp) begin
      spd = SpdW'(VelClamp);
    end else begin
      spd = vs_q[SpdW-1:0];
    end
  end

  assign recip_prod = RecipW'(prod_q) * RecipW'(RecipK);

  assign climb_s     = $signed(VelW'(cfg_i.climb_threshold));
  assign sink_s      = VelW'($signed(cfg_i.sink_threshold));
  assign above_climb = (vs_q > climb_s);
  assign below_climb = (vs_q < climb_s);
  assign below_sink  = (vs_q < sink_s);
  assign expired     = ((beep_start_q + TimeW'(period)) < now_q);

  always_comb begin
    act          = ACT_NONE;
    hz           = '0;
    sounding_d   = sounding_q;
    beep_start_d = beep_start_q;
    if (above_climb && !sounding_q && expired) begin
      act          = ACT_PLAY;
      hz           = freq_q;
      sounding_d   = 1'b1;
      beep_start_d = now_q;
    end else if (below_sink) begin
      act        = ACT_PLAY;
      hz         = SinkHz;
      sounding_d = 1'b1;
    end else if (sounding_q && below_climb) begin
      act        = ACT_SILENCE;
      sounding_d = 1'b0;
    end else if (sounding_q && expired) begin
      act          = ACT_SILENCE;
      sounding_d   = 1'b0;
      beep_start_d = now_q;
    end else if (sounding_q && above_climb) begin
      act = ACT_PLAY;
      hz  = freq_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sounding_q   <= 1'b0;
      beep_start_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.commit) begin
        sounding_q   <= sounding_d;
        beep_start_q <= beep_start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vs_q  <= vertical_speed_i;
      now_q <= now_ms_i;
    end
    if (cmd_i.prep) begin
      prod_q    <= ProdW'(spd) * FreqMul;
      divisor_q <= DivW'(spd) * PeriodMul + PeriodBase;
    end
    if (cmd_i.start) begin
      freq_q <= recip_prod[RecipShift +: HzW] + FreqBase;
    end
    if (cmd_i.commit) begin
      out_action_q <= act;
      out_hz_q     <= hz;
      out_level_q  <= (act == ACT_PLAY) ? cfg_i.tone_volume : '0;
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign action_o     = out_action_q;
  assign tone_hz_o    = out_hz_q;
  assign tone_level_o = out_level_q;

  // a held result that plays nothing
  assign out_quiet = out_valid_q && (out_action_q != ACT_PLAY);

  `ASSERT_IMPLIES(a_quiet_fields_zero, clk_i, rst_ni, out_quiet, {out_hz_q, out_level_q} == '0)

endmodule

/* src/vtc_ctrl.sv */
// ----------------------------------------------------------------------------
// vtc_ctrl
// Sequencer: capture, prepare, run the period divider, decide and hand off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtc_ctrl import vtc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PREP   = 5'b00010,
    ST_START  = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DECIDE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_START;
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // wait for the result register to drain
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEXT(a_accept_to_prep, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_PREP)
  `ASSERT_IMPLIES(a_ready_not_dividing, clk_i, rst_ni, in_ready_o, !sts_i.div_busy)

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives velocity samples into the tone controller and checks every tone
// request against a cycle-free model of the beep rules. A table of directed
// rows comes first, then randomised phases under changing register settings,
// with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import vtc_pkg::*;

  localparam int StallLimit = 2000;
  localparam int Phases     = 8;
  localparam int PhaseItems = 136;
  localparam int TailCycles = 30;

  typedef struct packed {
    action_e           action;
    logic [HzW-1:0]    hz;
    logic [LevelW-1:0] level;
  } tone_req_t;

  typedef struct packed {
    logic              is_cfg;
    logic [AddrW-3:0]  idx;
    logic [DataW-1:0]  wdata;
    logic [VelW-1:0]   vel;
    logic [TimeW-1:0]  now;
    logic              typed;
    tone_req_t         req;
  } plan_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  vtc_sample_if sample_ch ();
  vtc_result_if result_ch ();

  vario_tone_controller_core u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // register copies and tone state of the model
  logic [LevelW-1:0]      level_reg;
  logic [ThrW-1:0]        climb_reg;
  logic signed [ThrW-1:0] sink_reg;
  logic                   buzzing;
  logic [TimeW-1:0]       beep_start;

  tone_req_t tone_expected [$];
  tone_req_t head;
  int        errors;
  int        stall_cycles;
  logic      steady;

  plan_row_t plan [] = '{
    // after reset: nothing is due yet
    '{1'b0, RegToneVolume, 32'd0, 16'sd0, 32'd0, 1'b1, '{ACT_NONE, 11'd0, 4'd0}},
    '{1'b0, RegToneVolume, 32'd0, 16'sd10000, 32'd100, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'sd10000, 32'd224, 1'b1, '{ACT_PLAY, 11'd1796, 4'd10}},
    // above the clamp
    '{1'b0, RegToneVolume, 32'd0, 16'sh7FFF, 32'd225, 1'b1, '{ACT_PLAY, 11'd1796, 4'd10}},
    '{1'b0, RegToneVolume, 32'd0, 16'sh8000, 32'd230, 1'b1, '{ACT_PLAY, 11'd100, 4'd10}},
    '{1'b0, RegToneVolume, 32'd0, 16'hFFFF, 32'd231, 1'b1, '{ACT_SILENCE, 11'd0, 4'd0}},
    '{1'b0, RegToneVolume, 32'd0, 16'sd1, 32'd232, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'sd1, 32'd1150, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'sd0, 32'd1151, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'sd0, 32'd2076, 1'b0, '0},
    // time wrap around the top of the counter
    '{1'b0, RegToneVolume, 32'd0, 16'sd10000, 32'hFFFF_FFFF, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'sd10000, 32'd5, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'sd10000, 32'd223, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'hFF80, 32'd300, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'hFF7F, 32'd301, 1'b1, '{ACT_PLAY, 11'd100, 4'd10}},
    // volume above ten, thresholds at their tops
    '{1'b1, RegToneVolume, 32'hA5A5_A5AF, 16'd0, 32'd0, 1'b0, '0},
    '{1'b1, RegClimbThreshold, 32'h0000_00FF, 16'd0, 32'd0, 1'b0, '0},
    '{1'b1, RegSinkThreshold, 32'hFFFF_FF7F, 16'd0, 32'd0, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'sd126, 32'd400, 1'b1, '{ACT_PLAY, 11'd100, 4'd15}},
    '{1'b0, RegToneVolume, 32'd0, 16'sd255, 32'd401, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'sd200, 32'd402, 1'b0, '0},
    // silent volume, thresholds at their bottoms
    '{1'b1, RegToneVolume, 32'h0000_0000, 16'd0, 32'd0, 1'b0, '0},
    '{1'b1, RegClimbThreshold, 32'hFFFF_FF00, 16'd0, 32'd0, 1'b0, '0},
    '{1'b1, RegSinkThreshold, 32'h0000_0080, 16'd0, 32'd0, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'sd10000, 32'h8000_0000, 1'b1,
      '{ACT_PLAY, 11'd1796, 4'd0}},
    '{1'b0, RegToneVolume, 32'd0, 16'sh7FFF, 32'h8000_0000, 1'b0, '0},
    '{1'b0, RegToneVolume, 32'd0, 16'sh8000, 32'h8000_0001, 1'b0, '0}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic tone_req_t predict_tone(input logic signed [VelW-1:0] vel,
                                             input logic [TimeW-1:0] now);
    int          v;
    int unsigned mag;
    int unsigned hz;
    int unsigned period;
    logic [TimeW-1:0] deadline;
    tone_req_t   r;
    v = int'(vel);
    if (v > 10000) v = 10000;
    mag = (v < 0) ? 0 : v;
    hz = 141 * mag / 1000 + 386;
    period = 150000000 / (51 * mag + 162000);
    deadline = beep_start + period;
    r = '0;
    r.action = ACT_NONE;
    if (v > int'(climb_reg) && !buzzing && deadline < now) begin
      r.action = ACT_PLAY;
      r.hz = hz[HzW-1:0];
      buzzing = 1'b1;
      beep_start = now;
    end else if (v < int'(sink_reg)) begin
      r.action = ACT_PLAY;
      r.hz = SinkHz;
      buzzing = 1'b1;
    end else if (buzzing && v < int'(climb_reg)) begin
      r.action = ACT_SILENCE;
      buzzing = 1'b0;
    end else if (buzzing && deadline < now) begin
      r.action = ACT_SILENCE;
      buzzing = 1'b0;
      beep_start = now;
    end else if (buzzing && v > int'(climb_reg)) begin
      r.action = ACT_PLAY;
      r.hz = hz[HzW-1:0];
    end
    if (r.action == ACT_PLAY) r.level = level_reg;
    return r;
  endfunction

  task automatic write_reg(input logic [AddrW-3:0] idx, input logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegToneVolume:     level_reg = data[LevelW-1:0];
      RegClimbThreshold: climb_reg = data[ThrW-1:0];
      RegSinkThreshold:  sink_reg = data[ThrW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // valid is left high after a request so back-to-back samples need no toggle
  task automatic drive_sample(input logic [VelW-1:0] vel, input logic [TimeW-1:0] now);
    while (!steady && $urandom_range(0, 99) < 38) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.vertical_speed <= vel;
    sample_ch.now_ms <= now;
    do @(posedge clk_i); while (!sample_ch.ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (tone_expected.size() != 0);
  endtask

  always @(posedge clk_i) begin
    result_ch.ready <= steady || ($urandom_range(0, 99) >= 38);
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (tone_expected.size() == 0) begin
        $display("%0t: unexpected tone request, expected none, got action %0d hz %0d level %0d",
                 $time, result_ch.action, result_ch.tone_hz, result_ch.tone_level);
        errors++;
      end else begin
        head = tone_expected.pop_front();
        if (result_ch.action !== head.action) begin
          $display("%0t: action mismatch, expected %0d, got %0d",
                   $time, head.action, result_ch.action);
          errors++;
        end
        if (result_ch.tone_hz !== head.hz) begin
          $display("%0t: tone_hz mismatch, expected %0d, got %0d",
                   $time, head.hz, result_ch.tone_hz);
          errors++;
        end
        if (result_ch.tone_level !== head.level) begin
          $display("%0t: tone_level mismatch, expected %0d, got %0d",
                   $time, head.level, result_ch.tone_level);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted request or register access
  initial begin
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) || psel)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("vario_tone_controller_core verification failed");
    $finish;
  end

  initial begin
    int               ph;
    int               k;
    int               pick;
    int               vi;
    int               drain_at;
    logic [VelW-1:0]  vel;
    logic [TimeW-1:0] clock_ms;
    logic [DataW-1:0] data;
    logic [3:0]       vol_sel;
    logic [7:0]       climb_sel;
    logic [7:0]       sink_sel;
    tone_req_t        req;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.vertical_speed = '0;
    sample_ch.now_ms = '0;
    result_ch.ready = 1'b0;
    steady = 1'b0;
    errors = 0;
    level_reg = VolumeReset;
    climb_reg = ClimbReset;
    sink_reg = SinkReset;
    buzzing = 1'b0;
    beep_start = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        sample_ch.valid <= 1'b0;
        wait_drained();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        req = predict_tone(plan[i].vel, plan[i].now);
        if (plan[i].typed) req = plan[i].req;
        tone_expected.push_back(req);
        drive_sample(plan[i].vel, plan[i].now);
      end
    end

    clock_ms = $urandom();
    for (ph = 0; ph < Phases; ph++) begin
      sample_ch.valid <= 1'b0;
      wait_drained();
      vol_sel = 4'($urandom_range(0, 15));
      climb_sel = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 40));
      sink_sel = 8'($urandom_range(0, 255));
      case (ph)
        0: begin
          vol_sel = 4'd0;
          climb_sel = 8'h00;
          sink_sel = 8'h80;
        end
        1: begin
          vol_sel = 4'd15;
          climb_sel = 8'hFF;
          sink_sel = 8'h7F;
        end
        2: begin
          vol_sel = 4'd10;
          climb_sel = 8'hFF;
          sink_sel = 8'h80;
        end
        default: ;
      endcase
      data = $urandom();
      data[3:0] = vol_sel;
      write_reg(RegToneVolume, data);
      data = $urandom();
      data[7:0] = climb_sel;
      write_reg(RegClimbThreshold, data);
      data = $urandom();
      data[7:0] = sink_sel;
      write_reg(RegSinkThreshold, data);

      // one phase runs with both channels flat out
      steady = (ph == 3);
      drain_at = $urandom_range(10, PhaseItems - 10);
      for (k = 0; k < PhaseItems; k++) begin
        if (k == drain_at) begin
          sample_ch.valid <= 1'b0;
          wait_drained();
        end
        pick = $urandom_range(0, 99);
        if (pick < 75) clock_ms = clock_ms + $urandom_range(0, 1100);
        else if (pick < 85) clock_ms = clock_ms + $urandom_range(0, 3);
        else if (pick < 92) clock_ms = $urandom();
        else clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 1200);

        pick = $urandom_range(0, 99);
        if (pick < 30) vi = int'($urandom_range(0, 700)) - 300;
        else if (pick < 45) vi = int'(climb_reg) + int'($urandom_range(0, 4)) - 2;
        else if (pick < 55) vi = int'(sink_reg) + int'($urandom_range(0, 4)) - 2;
        else if (pick < 70) vi = $urandom_range(0, 12000);
        else if (pick < 85) vi = $urandom();
        else if (pick < 92) vi = $urandom_range(0, 1) ? 32767 : -32768;
        else vi = $urandom_range(9990, 10010);
        vel = vi[VelW-1:0];

        tone_expected.push_back(predict_tone(vel, clock_ms));
        drive_sample(vel, clock_ms);
      end
    end
    steady = 1'b0;

    sample_ch.valid <= 1'b0;
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("vario_tone_controller_core verification clean");
    end else begin
      $display("vario_tone_controller_core verification failed");
    end
    $finish;
  end

endmodule
